>>> design/fds_pkg.sv
// shared types, constants and register codes of the fragment depth shader
package fds_pkg;

  localparam int MAX_WIDTH_DEF    = 512;
  localparam int MAX_HEIGHT_DEF   = 512;
  localparam int TEX_MAX_SIDE_DEF = 256;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_EN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_EN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND   = 3'd6;

  localparam logic [9:0]  FRAME_SIZE_RST = 10'd512;
  localparam logic [8:0]  TEX_SIZE_RST   = 9'd2;
  localparam logic [23:0] BG_RST         = 24'hC0C0C0;

  // dividend is a Q8.24 magnitude shifted up by 16
  localparam int DVD_W   = 48;
  localparam int DVS_W   = 32;
  localparam int QUOT_W  = 32;
  localparam int SIZE_W  = 13;
  localparam int RES_W   = 10;
  localparam int PROD_W  = QUOT_W + RES_W + 1;

  localparam int GREY_SCALE = 230;
  localparam int CHAN_SCALE = 255;
  localparam int ROUND_HALF = 32'h8000;

  typedef enum logic [1:0] {
    OP_FRAGMENT = 2'd0,
    OP_TEXEL_WR = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ATTR_RED   = 3'd0,
    ATTR_GREEN = 3'd1,
    ATTR_BLUE  = 3'd2,
    ATTR_U     = 3'd3,
    ATTR_V     = 3'd4,
    ATTR_GREY  = 3'd5
  } attr_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_DEPTH_RD,
    ST_DEPTH_TEST,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_MUL,
    ST_POST,
    ST_TEX_RD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic  in_ready;
    logic  load_item;
    logic  clr_wr;
    logic  tex_wr;
    logic  depth_rd;
    logic  depth_wr;
    logic  div_start;
    logic  sat_en;
    logic  mul_en;
    logic  post_en;
    logic  grey_store;
    logic  tex_rd;
    logic  out_load;
    attr_e attr;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic in_valid;
    logic in_frame;
    logic tex_in;
    logic use_bg;
    logic tex_mode;
    logic col_mode;
    logic depth_fail;
    logic div_busy;
    logic clr_last;
    logic out_full;
  } sts_t;

endpackage

>>> design/fds_if.sv
// input and output channel interfaces of the fragment depth shader
interface fds_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic signed [11:0] coord_x;
  logic signed [11:0] coord_y;
  logic [31:0]        depth;
  logic signed [31:0] red_over_z;
  logic signed [31:0] green_over_z;
  logic signed [31:0] blue_over_z;
  logic signed [31:0] u_over_z;
  logic signed [31:0] v_over_z;
  logic [31:0]        texel_value;
  logic               use_background;

  modport source (
    output valid, operation, coord_x, coord_y, depth, red_over_z, green_over_z,
           blue_over_z, u_over_z, v_over_z, texel_value, use_background,
    input  ready
  );
  modport sink (
    input  valid, operation, coord_x, coord_y, depth, red_over_z, green_over_z,
           blue_over_z, u_over_z, v_over_z, texel_value, use_background,
    output ready
  );
endinterface

interface fds_out_if;
  logic        valid;
  logic        ready;
  logic [8:0]  pixel_x;
  logic [8:0]  pixel_y;
  logic [31:0] pixel_color;
  logic        pixel_write;
  logic        depth_pass;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, pixel_write, depth_pass,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, pixel_write, depth_pass,
    output ready
  );
endinterface

>>> design/fds_div.sv
// restoring unsigned divider, one quotient bit per cycle
module fds_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [fds_pkg::DVD_W-1:0] dividend_i,
  input  logic [fds_pkg::DVS_W-1:0] divisor_i,
  output logic                     busy_o,
  output logic [fds_pkg::DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(fds_pkg::DVD_W + 1);

  logic                      busy_q, busy_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [fds_pkg::DVS_W:0]   rem_q, rem_d;
  logic [fds_pkg::DVD_W-1:0] quo_q, quo_d;
  logic [fds_pkg::DVS_W-1:0] dvs_q, dvs_d;
  logic [fds_pkg::DVS_W:0]   rem_sh;
  logic                      ge;

  always_comb begin
    rem_sh = {rem_q[fds_pkg::DVS_W-1:0], quo_q[fds_pkg::DVD_W-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(fds_pkg::DVD_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
      quo_d = {quo_q[fds_pkg::DVD_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

>>> design/fds_dp.sv
// datapath: config registers, item registers, depth and texel stores, arithmetic
module fds_dp #(
  parameter int MAX_WIDTH    = fds_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = fds_pkg::MAX_HEIGHT_DEF,
  parameter int TEX_MAX_SIDE = fds_pkg::TEX_MAX_SIDE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  fds_pkg::cmd_t                 cmd_i,
  output fds_pkg::sts_t                 sts_o,
  fds_in_if.sink                        in_i,
  fds_out_if.source                     out_o
);

  localparam int SW     = fds_pkg::SIZE_W;
  localparam int RW     = fds_pkg::RES_W;
  localparam int DDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int DAW    = $clog2(DDEPTH);
  localparam int TDEPTH = TEX_MAX_SIDE * TEX_MAX_SIDE;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int TSW    = $clog2(TEX_MAX_SIDE);

  function automatic logic [SW-1:0] clamp_size(logic [SW-1:0] v, logic [SW-1:0] hi);
    logic [SW-1:0] r;
    r = v;
    if (v == '0) r = SW'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

  // configuration
  logic [9:0]  fw_q, fh_q;
  logic        col_en_q, tex_en_q;
  logic [8:0]  tw_q, th_q;
  logic [23:0] bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q     <= fds_pkg::FRAME_SIZE_RST;
      fh_q     <= fds_pkg::FRAME_SIZE_RST;
      col_en_q <= 1'b0;
      tex_en_q <= 1'b0;
      tw_q     <= fds_pkg::TEX_SIZE_RST;
      th_q     <= fds_pkg::TEX_SIZE_RST;
      bg_q     <= fds_pkg::BG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fds_pkg::CFG_FRAME_WIDTH:  fw_q     <= cfg_data_i[9:0];
        fds_pkg::CFG_FRAME_HEIGHT: fh_q     <= cfg_data_i[9:0];
        fds_pkg::CFG_COLOR_EN:     col_en_q <= cfg_data_i[0];
        fds_pkg::CFG_TEXTURE_EN:   tex_en_q <= cfg_data_i[0];
        fds_pkg::CFG_TEX_WIDTH:    tw_q     <= cfg_data_i[8:0];
        fds_pkg::CFG_TEX_HEIGHT:   th_q     <= cfg_data_i[8:0];
        fds_pkg::CFG_BACKGROUND:   bg_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item registers
  fds_pkg::op_e       op_q;
  logic signed [11:0] x_q, y_q;
  logic [31:0]        dep_q, tval_q;
  logic signed [31:0] r_q, g_q, b_q, u_q, v_q;
  logic               bgsel_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q    <= fds_pkg::op_e'(in_i.operation);
      x_q     <= in_i.coord_x;
      y_q     <= in_i.coord_y;
      dep_q   <= in_i.depth;
      r_q     <= in_i.red_over_z;
      g_q     <= in_i.green_over_z;
      b_q     <= in_i.blue_over_z;
      u_q     <= in_i.u_over_z;
      v_q     <= in_i.v_over_z;
      tval_q  <= in_i.texel_value;
      bgsel_q <= in_i.use_background;
    end
  end

  assign in_i.ready = cmd_i.in_ready;

  logic [SW-1:0] fw_c, fh_c, tw_c, th_c, x_mag, y_mag, fh_m1;
  logic          in_frame, tex_in;

  always_comb begin
    fw_c     = clamp_size(SW'(fw_q), SW'(MAX_WIDTH));
    fh_c     = clamp_size(SW'(fh_q), SW'(MAX_HEIGHT));
    tw_c     = clamp_size(SW'(tw_q), SW'(TEX_MAX_SIDE));
    th_c     = clamp_size(SW'(th_q), SW'(TEX_MAX_SIDE));
    x_mag    = SW'(x_q[10:0]);
    y_mag    = SW'(y_q[10:0]);
    fh_m1    = fh_c - SW'(1);
    in_frame = !x_q[11] && !y_q[11] && (x_mag < fw_c) && (y_mag < fh_c);
    tex_in   = !x_q[11] && !y_q[11] && (x_mag < SW'(TEX_MAX_SIDE)) &&
               (y_mag < SW'(TEX_MAX_SIDE));
  end

  // depth store, contents undefined until written
  logic [31:0]    depth_mem [DDEPTH];
  logic [31:0]    depth_rd_q;
  logic [DAW-1:0] depth_addr;

  assign depth_addr = DAW'(y_mag * MAX_WIDTH + x_mag);

  always_ff @(posedge clk_i) begin
    if (cmd_i.depth_wr) begin
      depth_mem[depth_addr] <= (op_q == fds_pkg::OP_CLEAR) ? 32'd0 : dep_q;
    end
    if (cmd_i.depth_rd) begin
      depth_rd_q <= depth_mem[depth_addr];
    end
  end

  // texel store, swept to zero after reset
  logic [31:0]    tex_mem [TDEPTH];
  logic [31:0]    tex_rd_q;
  logic [TAW-1:0] clr_cnt_q, tex_wr_addr, tex_rd_addr;
  logic [RW-1:0]  res_q [3];

  assign tex_wr_addr = TAW'(y_mag * TEX_MAX_SIDE + x_mag);
  assign tex_rd_addr = TAW'(res_q[1][TSW-1:0] * TEX_MAX_SIDE + res_q[0][TSW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      tex_mem[clr_cnt_q] <= 32'd0;
    end else if (cmd_i.tex_wr) begin
      tex_mem[tex_wr_addr] <= tval_q;
    end
    if (cmd_i.tex_rd) begin
      tex_rd_q <= tex_mem[tex_rd_addr];
    end
  end

  // divider operand selection
  logic signed [31:0]        attr_val;
  logic                      attr_neg;
  logic [31:0]               attr_mag;
  logic [SW-1:0]             grey_dvs;
  logic [fds_pkg::DVD_W-1:0] dividend;
  logic [fds_pkg::DVS_W-1:0] divisor;
  logic [fds_pkg::DVD_W-1:0] quotient;
  logic                      div_busy;

  always_comb begin
    unique case (cmd_i.attr)
      fds_pkg::ATTR_RED:   attr_val = r_q;
      fds_pkg::ATTR_GREEN: attr_val = g_q;
      fds_pkg::ATTR_BLUE:  attr_val = b_q;
      fds_pkg::ATTR_U:     attr_val = u_q;
      fds_pkg::ATTR_V:     attr_val = v_q;
      default:             attr_val = '0;
    endcase
    attr_neg = attr_val[31];
    attr_mag = attr_neg ? (~attr_val + 32'd1) : attr_val;
    grey_dvs = (fh_m1 == '0) ? SW'(1) : fh_m1;
    if (cmd_i.attr == fds_pkg::ATTR_GREY) begin
      dividend = fds_pkg::DVD_W'((fh_m1 - y_mag) * fds_pkg::GREY_SCALE);
      divisor  = fds_pkg::DVS_W'(grey_dvs);
    end else begin
      dividend = {attr_mag, 16'd0};
      divisor  = dep_q;
    end
  end

  fds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // saturate to Q16.16; a zero depth yields an all-ones quotient and saturates too
  logic signed [fds_pkg::QUOT_W-1:0] quot_q, quot_sat;
  logic signed [fds_pkg::PROD_W-1:0] prod_q;
  logic [RW-1:0]                     mult;
  logic                              is_chan;

  always_comb begin
    if (attr_neg) begin
      quot_sat = (quotient > fds_pkg::DVD_W'(32'h8000_0000)) ? 32'sh8000_0000 :
                 $signed(~quotient[31:0] + 32'd1);
    end else begin
      quot_sat = (quotient > fds_pkg::DVD_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF :
                 $signed(quotient[31:0]);
    end
    is_chan = (cmd_i.attr == fds_pkg::ATTR_RED) || (cmd_i.attr == fds_pkg::ATTR_GREEN) ||
              (cmd_i.attr == fds_pkg::ATTR_BLUE);
    if (is_chan) mult = RW'(fds_pkg::CHAN_SCALE);
    else if (cmd_i.attr == fds_pkg::ATTR_U) mult = RW'(tw_c - SW'(1));
    else mult = RW'(th_c - SW'(1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sat_en) quot_q <= quot_sat;
    if (cmd_i.mul_en) prod_q <= quot_q * $signed({1'b0, mult});
  end

  // scale back to integer units: channels truncate, texel indices round
  logic [fds_pkg::PROD_W-2:0] sum;
  logic [fds_pkg::PROD_W-18:0] shifted;
  logic [RW-1:0]              post_val;
  logic [1:0]                 slot;

  always_comb begin
    sum      = prod_q[fds_pkg::PROD_W-2:0] +
               (is_chan ? '0 : (fds_pkg::PROD_W-1)'(fds_pkg::ROUND_HALF));
    shifted  = sum[fds_pkg::PROD_W-2:16];
    if (prod_q[fds_pkg::PROD_W-1]) post_val = '0;
    else if (shifted > (fds_pkg::PROD_W-17)'(mult)) post_val = mult;
    else post_val = shifted[RW-1:0];
    unique case (cmd_i.attr)
      fds_pkg::ATTR_GREEN, fds_pkg::ATTR_V: slot = 2'd1;
      fds_pkg::ATTR_BLUE:                   slot = 2'd2;
      default:                              slot = 2'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post_en) begin
      res_q[slot] <= post_val;
    end else if (cmd_i.grey_store) begin
      res_q[0] <= quotient[RW-1:0];
    end
  end

  // result register
  logic        out_valid_q, out_valid_d;
  logic [8:0]  px_q, py_q, px_d, py_d;
  logic [31:0] pc_q, pc_d;
  logic        pw_q, pw_d, pass_q, pass_d;
  logic        depth_fail;
  logic [7:0]  grey;

  assign depth_fail = dep_q < depth_rd_q;
  assign grey       = res_q[0][7:0];

  always_comb begin
    px_d   = '0;
    py_d   = '0;
    pc_d   = '0;
    pw_d   = 1'b0;
    pass_d = 1'b0;
    unique case (op_q)
      fds_pkg::OP_CLEAR: begin
        if (in_frame) begin
          px_d = x_q[8:0];
          py_d = y_q[8:0];
          pc_d = bgsel_q ? {8'd0, bg_q} : {8'd0, grey, grey, grey};
          pw_d = 1'b1;
        end
      end
      fds_pkg::OP_FRAGMENT: begin
        if (in_frame) begin
          px_d = x_q[8:0];
          py_d = y_q[8:0];
          if (!depth_fail) begin
            pass_d = 1'b1;
            if (tex_en_q) begin
              pc_d = tex_rd_q;
              pw_d = 1'b1;
            end else if (col_en_q) begin
              pc_d = {8'd0, res_q[0][7:0], res_q[1][7:0], res_q[2][7:0]};
              pw_d = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    out_valid_d = cmd_i.out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      px_q   <= px_d;
      py_q   <= py_d;
      pc_q   <= pc_d;
      pw_q   <= pw_d;
      pass_q <= pass_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_x     = px_q;
  assign out_o.pixel_y     = py_q;
  assign out_o.pixel_color = pc_q;
  assign out_o.pixel_write = pw_q;
  assign out_o.depth_pass  = pass_q;

  always_comb begin
    sts_o.op         = op_q;
    sts_o.in_valid   = in_i.valid;
    sts_o.in_frame   = in_frame;
    sts_o.tex_in     = tex_in;
    sts_o.use_bg     = bgsel_q;
    sts_o.tex_mode   = tex_en_q;
    sts_o.col_mode   = col_en_q;
    sts_o.depth_fail = depth_fail;
    sts_o.div_busy   = div_busy;
    sts_o.clr_last   = clr_cnt_q == TAW'(TDEPTH - 1);
    sts_o.out_full   = out_valid_q && !out_o.ready;
  end

endmodule

>>> design/fds_ctrl.sv
// controller state machine sequencing one item through the datapath
module fds_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fds_pkg::sts_t sts_i,
  output fds_pkg::cmd_t cmd_o
);

  fds_pkg::state_e state_q, state_d;
  fds_pkg::attr_e  attr_q, attr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fds_pkg::ST_CLEAR;
      attr_q  <= fds_pkg::ATTR_RED;
    end else begin
      state_q <= state_d;
      attr_q  <= attr_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    attr_d     = attr_q;
    cmd_o      = '0;
    cmd_o.attr = attr_q;
    unique case (state_q)
      fds_pkg::ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) state_d = fds_pkg::ST_IDLE;
      end
      fds_pkg::ST_IDLE: begin
        cmd_o.in_ready  = 1'b1;
        cmd_o.load_item = sts_i.in_valid;
        if (sts_i.in_valid) state_d = fds_pkg::ST_DISPATCH;
      end
      fds_pkg::ST_DISPATCH: begin
        state_d = fds_pkg::ST_DONE;
        unique case (sts_i.op)
          fds_pkg::OP_TEXEL_WR: cmd_o.tex_wr = sts_i.tex_in;
          fds_pkg::OP_CLEAR: begin
            if (sts_i.in_frame) begin
              cmd_o.depth_wr = 1'b1;
              if (!sts_i.use_bg) begin
                attr_d  = fds_pkg::ATTR_GREY;
                state_d = fds_pkg::ST_DIV_START;
              end
            end
          end
          fds_pkg::OP_FRAGMENT: begin
            if (sts_i.in_frame) state_d = fds_pkg::ST_DEPTH_RD;
          end
          default: ;
        endcase
      end
      fds_pkg::ST_DEPTH_RD: begin
        cmd_o.depth_rd = 1'b1;
        state_d        = fds_pkg::ST_DEPTH_TEST;
      end
      fds_pkg::ST_DEPTH_TEST: begin
        state_d = fds_pkg::ST_DONE;
        if (!sts_i.depth_fail) begin
          cmd_o.depth_wr = 1'b1;
          if (sts_i.tex_mode) begin
            attr_d  = fds_pkg::ATTR_U;
            state_d = fds_pkg::ST_DIV_START;
          end else if (sts_i.col_mode) begin
            attr_d  = fds_pkg::ATTR_RED;
            state_d = fds_pkg::ST_DIV_START;
          end
        end
      end
      fds_pkg::ST_DIV_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = fds_pkg::ST_DIV_WAIT;
      end
      fds_pkg::ST_DIV_WAIT: begin
        if (!sts_i.div_busy) begin
          if (attr_q == fds_pkg::ATTR_GREY) begin
            cmd_o.grey_store = 1'b1;
            state_d          = fds_pkg::ST_DONE;
          end else begin
            cmd_o.sat_en = 1'b1;
            state_d      = fds_pkg::ST_MUL;
          end
        end
      end
      fds_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = fds_pkg::ST_POST;
      end
      fds_pkg::ST_POST: begin
        cmd_o.post_en = 1'b1;
        state_d       = fds_pkg::ST_DIV_START;
        unique case (attr_q)
          fds_pkg::ATTR_RED:   attr_d = fds_pkg::ATTR_GREEN;
          fds_pkg::ATTR_GREEN: attr_d = fds_pkg::ATTR_BLUE;
          fds_pkg::ATTR_U:     attr_d = fds_pkg::ATTR_V;
          fds_pkg::ATTR_V:     state_d = fds_pkg::ST_TEX_RD;
          default:             state_d = fds_pkg::ST_DONE;
        endcase
      end
      fds_pkg::ST_TEX_RD: begin
        cmd_o.tex_rd = 1'b1;
        state_d      = fds_pkg::ST_DONE;
      end
      fds_pkg::ST_DONE: begin
        if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = fds_pkg::ST_IDLE;
        end
      end
      default: state_d = fds_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> design/fragment_depth_shader_top.sv
// texel writes, rejects and no-ops go straight to the result; a fragment in the frame
// adds a depth read and test, and if it passes, divider runs for u and v and a texel read
// or for red, green and blue; one item at a time, the next can be taken in the cycle after
// the result is loaded; each attribute, like the grey level of a clear, takes its own pass
// through the shared 48-step divider; a finished result waits in the output register while
// the next item is taken in; after reset the texel store is swept to zero before any item
module fragment_depth_shader_top #(
  parameter int MAX_WIDTH    = fds_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT   = fds_pkg::MAX_HEIGHT_DEF,
  parameter int TEX_MAX_SIDE = fds_pkg::TEX_MAX_SIDE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fds_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  fds_in_if.sink                        in_i,
  fds_out_if.source                     out_o
);

  fds_pkg::cmd_t cmd;
  fds_pkg::sts_t sts;

  fds_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  fds_dp #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .TEX_MAX_SIDE (TEX_MAX_SIDE)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_i       (in_i),
    .out_o      (out_o)
  );

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !sts.out_full)
    else $error("result loaded over an untaken beat");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second beat accepted while an item is in flight");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |=> sts.div_busy)
    else $error("divider did not start");

  a_tex_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !(cmd.tex_wr || cmd.in_ready))
    else $error("texel sweep overlaps item traffic");
`endif

endmodule
